@@ hw/rtl/hkrp_pkg.sv @@
package hkrp_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CODE_W     = 16;
    localparam int unsigned HELD_W     = 8;
    localparam int unsigned TICKS_W    = 5;
    localparam int unsigned MS_W       = 9;
    localparam int unsigned ACT_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0]  TICK_MS     = 32'd10;
    localparam logic [TICKS_W-1:0] DELAY_MIN   = 5'd5;
    localparam logic [TICKS_W-1:0] DELAY_MAX   = 5'd30;
    localparam logic [TICKS_W-1:0] REPEAT_MIN  = 5'd5;
    localparam logic [TICKS_W-1:0] REPEAT_MAX  = 5'd20;
    localparam logic [TICKS_W-1:0] DELAY_RST   = 5'd20;
    localparam logic [TICKS_W-1:0] REPEAT_RST  = 5'd8;
    localparam logic [CODE_W-1:0]  FIRST_RST   = 16'd4;
    localparam logic [CODE_W-1:0]  LAST_RST    = 16'd164;
    localparam logic [HELD_W-1:0]  HELD_MAX    = 8'd255;
    localparam logic [HELD_W-1:0]  HELD_PAIR   = 8'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_UNITS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_UNITS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASIC_FIRST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASIC_LAST     = 3'd4;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_POLL = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 2'd0,
        ACT_EMPTY   = 2'd1,
        ACT_RESTORE = 2'd2
    } action_t;

    typedef struct packed {
        logic                clear;
        logic                feature_enable;
        logic [TICKS_W-1:0]  hold_units;
        logic [TICKS_W-1:0]  period_units;
        logic [CODE_W-1:0]   basic_first;
        logic [CODE_W-1:0]   basic_last;
    } cfg_t;

    typedef struct packed {
        logic               opcode;
        logic [TIME_W-1:0]  now_ms;
        logic [CODE_W-1:0]  key_code;
        logic               key_pressed;
        logic               key_excluded;
    } item_t;

    typedef struct packed {
        action_t            report_action;
        logic               repeat_mode;
        logic [HELD_W-1:0]  held_count;
    } result_t;

    function automatic logic [TICKS_W-1:0] clamp_ticks(
        input logic [TICKS_W-1:0] v,
        input logic [TICKS_W-1:0] lo,
        input logic [TICKS_W-1:0] hi
    );
        logic [TICKS_W-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // times ten as (x8 + x2)
    function automatic logic [MS_W-1:0] ticks_to_ms(input logic [TICKS_W-1:0] t);
        return {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
    endfunction

endpackage

@@ hw/rtl/hkrp_cfg.sv @@
module hkrp_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hkrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hkrp_pkg::CFG_DATA_W-1:0] cfg_data,
    output hkrp_pkg::cfg_t                  cfg
);
    import hkrp_pkg::*;

    logic               enable_reg;
    logic [TICKS_W-1:0] delay_reg;
    logic [TICKS_W-1:0] repeat_reg;
    logic [CODE_W-1:0]  first_reg;
    logic [CODE_W-1:0]  last_reg;

    logic               enable_next;
    logic [TICKS_W-1:0] delay_next;
    logic [TICKS_W-1:0] repeat_next;
    logic [CODE_W-1:0]  first_next;
    logic [CODE_W-1:0]  last_next;
    logic               clear;

    always_comb
    begin
        enable_next = enable_reg;
        delay_next  = delay_reg;
        repeat_next = repeat_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        clear       = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FEATURE_ENABLE:
                begin
                    enable_next = cfg_data[0];
                    clear       = (cfg_data[0] != enable_reg);
                end
                REG_HOLD_UNITS:
                begin
                    delay_next = clamp_ticks(cfg_data[TICKS_W-1:0], DELAY_MIN, DELAY_MAX);
                    clear      = (delay_next != delay_reg);
                end
                REG_PERIOD_UNITS:
                begin
                    repeat_next = clamp_ticks(cfg_data[TICKS_W-1:0], REPEAT_MIN, REPEAT_MAX);
                    clear       = (repeat_next != repeat_reg);
                end
                REG_BASIC_FIRST:
                begin
                    first_next = cfg_data[CODE_W-1:0];
                end
                REG_BASIC_LAST:
                begin
                    last_next = cfg_data[CODE_W-1:0];
                end
                default:
                begin
                    clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            delay_reg  <= DELAY_RST;
            repeat_reg <= REPEAT_RST;
            first_reg  <= FIRST_RST;
            last_reg   <= LAST_RST;
        end
        else
        begin
            enable_reg <= enable_next;
            delay_reg  <= delay_next;
            repeat_reg <= repeat_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
        end
    end

    assign cfg.clear          = clear;
    assign cfg.feature_enable = enable_reg;
    assign cfg.hold_units     = delay_reg;
    assign cfg.period_units   = repeat_reg;
    assign cfg.basic_first    = first_reg;
    assign cfg.basic_last     = last_reg;

endmodule

@@ hw/rtl/hkrp_engine.sv @@
module hkrp_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  hkrp_pkg::item_t   item,
    input  hkrp_pkg::cfg_t    cfg,
    output hkrp_pkg::result_t result
);
    import hkrp_pkg::*;

    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] before_reg;
    logic              mode_reg;
    logic              wanted_reg;
    logic [TIME_W-1:0] period_start_reg;
    logic [TIME_W-1:0] last_key_reg;
    logic [TIME_W-1:0] last_pulse_reg;
    logic              spacing_reg;
    logic              restore_reg;

    logic [HELD_W-1:0] held_next;
    logic [HELD_W-1:0] before_next;
    logic              mode_next;
    logic              wanted_next;
    logic [TIME_W-1:0] period_start_next;
    logic [TIME_W-1:0] last_key_next;
    logic [TIME_W-1:0] last_pulse_next;
    logic              spacing_next;
    logic              restore_next;

    action_t           action;
    logic [TIME_W-1:0] hold_wait;
    logic [TIME_W-1:0] period_len;
    logic [TIME_W-1:0] key_age;
    logic [TIME_W-1:0] period_age;
    logic [TIME_W-1:0] pulse_age;
    logic              basic_key;
    logic              mode_entry;
    logic              mode_after;
    logic              wanted_kept;
    logic              wanted_due;
    logic              period_due;
    logic              too_soon;

    assign hold_wait  = {{(TIME_W-MS_W){1'b0}}, ticks_to_ms(cfg.hold_units)};
    assign period_len = {{(TIME_W-MS_W){1'b0}}, ticks_to_ms(cfg.period_units)};
    assign key_age    = item.now_ms - last_key_reg;
    assign period_age = item.now_ms - period_start_reg;
    assign pulse_age  = item.now_ms - last_pulse_reg;
    assign basic_key  = (item.key_code >= cfg.basic_first) && (item.key_code <= cfg.basic_last);

    assign mode_entry  = !mode_reg && (held_reg >= HELD_PAIR) && (key_age >= hold_wait);
    assign mode_after  = mode_entry || (mode_reg && (held_reg != '0));
    assign wanted_kept = wanted_reg && !(mode_reg && (held_reg == '0));
    assign wanted_due  = wanted_kept || (mode_after && ((held_reg >= HELD_PAIR)
                         || ((held_reg == HELD_W'(1)) && (before_reg == HELD_PAIR))));
    // on entry the period start lies ten ms ahead, so the wrapped age is always due
    assign period_due  = mode_entry || (period_age >= period_len);
    assign too_soon    = spacing_reg && (pulse_age < period_len);

    always_comb
    begin
        held_next         = held_reg;
        before_next       = before_reg;
        mode_next         = mode_reg;
        wanted_next       = wanted_reg;
        period_start_next = period_start_reg;
        last_key_next     = last_key_reg;
        last_pulse_next   = last_pulse_reg;
        spacing_next      = spacing_reg;
        restore_next      = restore_reg;
        action            = ACT_NONE;
        if (cfg.clear)
        begin
            held_next         = '0;
            before_next       = '0;
            mode_next         = 1'b0;
            wanted_next       = 1'b0;
            period_start_next = '0;
            last_key_next     = '0;
            last_pulse_next   = '0;
            spacing_next      = 1'b0;
        end
        else if (step)
        begin
            if (item.opcode == OP_POLL)
            begin
                if (restore_reg)
                begin
                    restore_next    = 1'b0;
                    last_pulse_next = item.now_ms;
                    spacing_next    = 1'b1;
                    action          = ACT_RESTORE;
                end
                else if (cfg.feature_enable)
                begin
                    mode_next   = mode_after;
                    wanted_next = wanted_kept;
                    if (mode_entry)
                    begin
                        period_start_next = item.now_ms + TICK_MS;
                    end
                    if (period_due)
                    begin
                        before_next = held_reg;
                        if (!wanted_due)
                        begin
                            period_start_next = item.now_ms;
                        end
                        else if (too_soon)
                        begin
                            wanted_next = 1'b1;
                        end
                        else
                        begin
                            wanted_next       = 1'b0;
                            period_start_next = item.now_ms;
                            restore_next      = 1'b1;
                            action            = ACT_EMPTY;
                        end
                    end
                end
            end
            else if (cfg.feature_enable && !item.key_excluded && basic_key)
            begin
                if (item.key_pressed)
                begin
                    if (held_reg != HELD_MAX)
                    begin
                        held_next = held_reg + HELD_W'(1);
                    end
                end
                else if (held_reg != '0)
                begin
                    held_next = held_reg - HELD_W'(1);
                end
                last_key_next = item.now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= '0;
            before_reg       <= '0;
            mode_reg         <= 1'b0;
            wanted_reg       <= 1'b0;
            period_start_reg <= '0;
            last_key_reg     <= '0;
            last_pulse_reg   <= '0;
            spacing_reg      <= 1'b0;
            restore_reg      <= 1'b0;
        end
        else
        begin
            held_reg         <= held_next;
            before_reg       <= before_next;
            mode_reg         <= mode_next;
            wanted_reg       <= wanted_next;
            period_start_reg <= period_start_next;
            last_key_reg     <= last_key_next;
            last_pulse_reg   <= last_pulse_next;
            spacing_reg      <= spacing_next;
            restore_reg      <= restore_next;
        end
    end

    assign result.report_action = action;
    assign result.repeat_mode   = mode_next;
    assign result.held_count    = held_next;

endmodule

@@ hw/rtl/held_keys_release_pulser_core.sv @@
// channel | direction | handshake        | payload
// input   | in        | in_valid/ready   | opcode, now_ms, key_code, key_pressed, key_excluded
// output  | out       | out_valid/ready  | report_action, repeat_mode, held_count
// config  | in        | cfg_we           | cfg_index, cfg_data
//
// A beat accepted into the input register is processed once the output can take its result;
// that result is registered in the result register and offered from there.
// One beat per cycle sustained while the output is ready.
// rst_n clears the valid flags, the settings and all key and timer state at once.
// A stalled output holds the result register; the input register takes a new beat
// while it is empty or its contents move on in the same cycle.
module held_keys_release_pulser_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [hkrp_pkg::TIME_W-1:0]     now_ms,
    input  logic [hkrp_pkg::CODE_W-1:0]     key_code,
    input  logic                            key_pressed,
    input  logic                            key_excluded,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hkrp_pkg::ACT_W-1:0]      report_action,
    output logic                            repeat_mode,
    output logic [hkrp_pkg::HELD_W-1:0]     held_count,
    input  logic                            cfg_we,
    input  logic [hkrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hkrp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hkrp_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    result_t result;
    result_t result_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    hkrp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hkrp_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.opcode       <= opcode;
            item_reg.now_ms       <= now_ms;
            item_reg.key_code     <= key_code;
            item_reg.key_pressed  <= key_pressed;
            item_reg.key_excluded <= key_excluded;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign report_action = result_reg.report_action;
    assign repeat_mode   = result_reg.repeat_mode;
    assign held_count    = result_reg.held_count;

    a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed beat did not reach the result register");

    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(item_reg)))
        else $error("waiting beat lost from the input register");

    a_pulse_in_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.report_action == ACT_EMPTY))
        |-> (result_reg.repeat_mode && (result_reg.held_count != '0)))
        else $error("empty report outside repeat mode");

    a_restore_after_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (result.report_action == ACT_EMPTY))
        |=> (u_engine.restore_reg))
        else $error("empty report without a restore pending");

endmodule
